@@ rtl/mpve_pkg.sv @@
`timescale 1ns / 1ps
// Package for the media parameter value extractor: phase codes, result kinds,
// character constants, the result item type and the character class functions.
// Used by every module under rtl/.
package mpve_pkg;

  localparam int KEY_MAX_LEN   = 8;
  localparam int KEY_W         = 64;
  localparam int KEY_LEN_W     = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int OUT_DEPTH_DEF = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

  // parse phases
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_SKIPWS       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_NAME         = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP_START   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SKIP_PLAIN   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SKIP_QUOTED  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SKIP_ESC     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_GET_START    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_GET_PLAIN    = 4'd7;
  localparam logic [PHASE_W-1:0] PH_GET_QUOTED   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_GET_ESC      = 4'd9;
  localparam logic [PHASE_W-1:0] PH_DONE_FOUND   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_DONE_MISSING = 4'd11;

  // result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } res_t;

  // up to two result items pushed at once, first in a
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'h21) && (c <= 8'h7E);
    if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LT || c == CH_GT ||
        c == CH_AT || c == CH_COMMA || c == CH_SEMI || c == CH_COLON ||
        c == CH_BSLASH || c == CH_DQUOTE || c == CH_SLASH || c == CH_LBRACK ||
        c == CH_RBRACK || c == CH_QMARK || c == CH_EQUALS || c == CH_LBRACE ||
        c == CH_RBRACE) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

@@ rtl/mpve_parser.sv @@
`timescale 1ns / 1ps
// Input register and single-pass parse step of the extractor.
// Depends on mpve_pkg.
module mpve_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mpve_pkg::KEY_W-1:0]     key_chars,
  input  logic [mpve_pkg::KEY_LEN_W-1:0] key_length,
  input  logic                           room,
  output mpve_pkg::push_t                push
);
  import mpve_pkg::*;

  localparam logic [KEY_LEN_W-1:0] KMAX     = KEY_LEN_W'(KEY_MAX_LEN);
  localparam logic [KEY_LEN_W-1:0] POS_SAT  = KEY_LEN_W'(KEY_MAX_LEN + 1);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic                 fire;

  logic [PHASE_W-1:0]   phase_r, phase_nxt, phase_eff;
  logic [KEY_LEN_W-1:0] pos_r, pos_nxt, pos_eff;
  logic                 match_r, match_nxt, match_eff;

  logic [KEY_LEN_W-1:0] klen;
  logic [7:0]           key_byte;
  logic                 hit;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 end_str;
  logic                 found;
  res_t                 status;
  res_t                 value;

  assign fire     = s1_valid_r && room;
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  assign klen     = (key_length > KMAX) ? KMAX : key_length;
  assign key_byte = 8'(key_chars >> {pos_eff[2:0], 3'b000});
  assign hit      = (klen != '0) && match_eff && (pos_eff == klen);
  assign end_str  = (s1_byte_r == CH_NUL) || s1_last_r;

  always_comb begin
    phase_eff = phase_r;
    pos_eff   = pos_r;
    match_eff = match_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    emit      = 1'b0;
    emit_byte = 8'h00;
    found     = 1'b0;
    if (s1_byte_r != CH_NUL) begin
      // a non-blank byte opens a name; a non-quote opens a plain value
      if (phase_r == PH_SKIPWS && !is_blank(s1_byte_r)) begin
        phase_eff = PH_NAME;
        pos_eff   = '0;
        match_eff = 1'b1;
      end
      if (phase_r == PH_GET_START && s1_byte_r != CH_DQUOTE) begin
        phase_eff = PH_GET_PLAIN;
      end
      unique case (phase_eff)
        PH_NAME: begin
          pos_nxt   = pos_eff;
          match_nxt = match_eff;
          if (s1_byte_r == CH_SEMI) begin
            phase_nxt = hit ? PH_DONE_MISSING : PH_SKIPWS;
          end else if (s1_byte_r == CH_EQUALS) begin
            phase_nxt = hit ? PH_GET_START : PH_SKIP_START;
          end else begin
            phase_nxt = PH_NAME;
            if (pos_eff < klen) begin
              if (fold(s1_byte_r) != fold(key_byte)) match_nxt = 1'b0;
            end else begin
              match_nxt = 1'b0;
            end
            if (pos_eff < POS_SAT) pos_nxt = pos_eff + 1'b1;
          end
        end
        PH_SKIP_START: begin
          if (s1_byte_r == CH_DQUOTE)    phase_nxt = PH_SKIP_QUOTED;
          else if (s1_byte_r == CH_SEMI) phase_nxt = PH_SKIPWS;
          else                           phase_nxt = PH_SKIP_PLAIN;
        end
        PH_SKIP_PLAIN: begin
          if (s1_byte_r == CH_SEMI) phase_nxt = PH_SKIPWS;
        end
        PH_SKIP_QUOTED: begin
          if (s1_byte_r == CH_DQUOTE)        phase_nxt = PH_SKIP_PLAIN;
          else if (s1_byte_r == CH_BSLASH)   phase_nxt = PH_SKIP_ESC;
        end
        PH_SKIP_ESC: begin
          phase_nxt = PH_SKIP_QUOTED;
        end
        PH_GET_START: begin
          phase_nxt = PH_GET_QUOTED;
        end
        PH_GET_PLAIN: begin
          if (is_token(s1_byte_r)) begin
            phase_nxt = PH_GET_PLAIN;
            emit      = 1'b1;
            emit_byte = s1_byte_r;
          end else begin
            phase_nxt = PH_DONE_FOUND;
          end
        end
        PH_GET_QUOTED: begin
          if (s1_byte_r == CH_DQUOTE) begin
            phase_nxt = PH_DONE_FOUND;
          end else if (s1_byte_r == CH_BSLASH) begin
            phase_nxt = PH_GET_ESC;
          end else begin
            emit      = 1'b1;
            emit_byte = s1_byte_r;
          end
        end
        PH_GET_ESC: begin
          phase_nxt = PH_GET_QUOTED;
          emit      = 1'b1;
          emit_byte = s1_byte_r;
        end
        default: ;
      endcase
    end
    if (end_str) begin
      found     = (phase_nxt >= PH_GET_START) && (phase_nxt <= PH_DONE_FOUND);
      phase_nxt = PH_SKIPWS;
      pos_nxt   = '0;
      match_nxt = 1'b1;
    end
  end

  always_comb begin
    value.data  = emit_byte;
    value.kind  = KIND_VALUE;
    value.last  = 1'b0;
    status.data = 8'h00;
    status.kind = found ? KIND_FOUND : KIND_MISSING;
    status.last = 1'b1;
    push.a      = emit ? value : status;
    push.b      = status;
    push.n      = 2'd0;
    if (fire) begin
      push.n = 2'({1'b0, emit} + {1'b0, end_str});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIPWS;
      pos_r   <= '0;
      match_r <= 1'b1;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_str |=> phase_r == PH_SKIPWS && pos_r == '0 && match_r)
    else $error("parse state not cleared after end of string");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DONE_MISSING)
    else $error("parse phase out of range");
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_SAT)
    else $error("name position beyond saturation");

endmodule

@@ rtl/mpve_out_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two result items a cycle, hands out one.
// Depends on mpve_pkg.
module mpve_out_fifo #(
  parameter int DEPTH = mpve_pkg::OUT_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mpve_pkg::push_t push,
  output logic            room,
  output mpve_pkg::res_t  out_item,
  output logic            out_valid,
  input  logic            out_ready
);
  import mpve_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, wr1, wr2, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr1       = inc(wr_r);
  assign wr2       = inc(wr1);
  assign room      = cnt_r <= CW'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    rd_nxt  = pop ? inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
    unique case (push.n)
      2'd1:    wr_nxt = wr1;
      2'd2:    wr_nxt = wr2;
      default: wr_nxt = wr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push.n != 2'd0) mem_r[wr_r] <= push.a;
    if (push.n == 2'd2) mem_r[wr1]  <= push.b;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push into result queue without room");
  a_pair_status: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.b.last && push.a.kind == KIND_VALUE)
    else $error("paired push is not value byte then status");

endmodule

@@ rtl/media_param_value_extractor_unit.sv @@
`timescale 1ns / 1ps
// Top level of the media parameter value extractor: configuration registers,
// parse stage and result queue. Depends on mpve_pkg, mpve_parser, mpve_out_fifo.
//
//  channel  direction  tdata            tuser     tlast
//  in_      slave      [7:0] byte       -         last byte of string
//  out_     master     [7:0] value byte [1:0] kind final status item
//  cfg_     write      cfg_wdata[63:0], cfg_index selects register
//
// One item is accepted per cycle while the result queue has room for two
// results; from acceptance, a result passes the input register and then a queue
// entry before it reaches out_. An item that yields a value byte and the status
// puts two results into the queue, so the out_ port paces a burst of such items.
// Reset is synchronous on rst_n low: parse state, queue pointers and registers
// return to their reset values. A stall on out_ fills the queue and then drops
// in_tready; no item is lost or repeated.
module media_param_value_extractor_unit #(
  parameter int OUT_DEPTH = mpve_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic [1:0]                     out_tuser,  // [1:0] out_kind
  output logic                           out_tlast,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [mpve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpve_pkg::KEY_W-1:0]     cfg_wdata
);
  import mpve_pkg::*;

  logic [KEY_W-1:0]     key_chars_r;
  logic [KEY_LEN_W-1:0] key_length_r;
  logic                 room;
  push_t                push;
  res_t                 out_item;

  // hold the key registers; write them only while no item is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r  <= '0;
      key_length_r <= KEY_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  key_chars_r  <= cfg_wdata;
        REG_KEY_LENGTH: key_length_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register the byte, advance the parse phase, build up to two results
  mpve_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .key_chars  (key_chars_r),
    .key_length (key_length_r),
    .room       (room),
    .push       (push)
  );

  // queue results so a value byte and its status can leave on separate cycles
  mpve_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_item  (out_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = out_item.data;
  assign out_tuser = out_item.kind;
  assign out_tlast = out_item.last;

endmodule

@@ tb/tb_media_param_value_extractor_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for media_param_value_extractor_unit: parameter strings in,
// extracted value bytes and found/missing status out, checked against a parser model.
// Depends on mpve_pkg and the RTL under rtl/.
module tb_media_param_value_extractor_unit;
  import mpve_pkg::*;

  localparam int STUCK_LIMIT = 2000;   // cycles without any handshake or write
  localparam int SETTLE      = 8;      // cycles to let the pipe empty out

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [7:0] in_byte
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [7:0] out_byte
  logic [1:0]           out_tuser;       // [1:0] out_kind
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_wdata = '0;

  // parser model: its own copy of the registers and the scan state
  logic [63:0]  key_bytes = '0;
  logic [3:0]   key_len = 4'd1;
  logic [3:0]   parse_ph = PH_SKIPWS;
  int           name_pos = 0;
  bit           name_ok = 1'b1;

  char_item_t   pending_chars[$];
  res_t         predicted_results[$];
  int           phase_items;
  int           mismatches = 0;
  bit           idling = 1'b1;
  bit           random_part = 1'b0;
  int           long_holds = 0;
  int           in_gap = 0;
  int           out_hold = 0;
  int           stuck = 0;
  string        token_set =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-.^_`|~";
  string        stop_set = "\t ,()<>@:/[]?{};";

  media_param_value_extractor_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Character classes and the parser model
  // ---------------------------------------------------------------------------
  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit token_char(input logic [7:0] c);
    if (c < 8'h21 || c > 8'h7E) return 1'b0;
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_AT, CH_COMMA, CH_SEMI, CH_COLON,
      CH_BSLASH, CH_DQUOTE, CH_SLASH, CH_LBRACK, CH_RBRACK, CH_QMARK,
      CH_EQUALS, CH_LBRACE, CH_RBRACE: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] ascii_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Advance the scan by one non-zero character; return 1 with v set when it
  // yields a value byte.
  function automatic bit advance_parse(input logic [7:0] c, output logic [7:0] v);
    int k;
    bit hit;
    v = '0;
    k = (key_len > KEY_MAX_LEN) ? KEY_MAX_LEN : int'(key_len);
    // leading whitespace is dropped; anything else opens a new name
    if (parse_ph == PH_SKIPWS) begin
      if (blank_char(c)) return 1'b0;
      parse_ph = PH_NAME;
      name_pos = 0;
      name_ok = 1'b1;
    end
    // a value that does not open with a quote is a plain token run
    if (parse_ph == PH_GET_START && c != CH_DQUOTE) parse_ph = PH_GET_PLAIN;
    hit = (k != 0) && name_ok && (name_pos == k);
    case (parse_ph)
      PH_NAME: begin
        if (c == CH_SEMI) begin
          parse_ph = hit ? PH_DONE_MISSING : PH_SKIPWS;
        end else if (c == CH_EQUALS) begin
          parse_ph = hit ? PH_GET_START : PH_SKIP_START;
        end else begin
          if (name_pos < k) begin
            if (ascii_lower(c) != ascii_lower(key_bytes[8*name_pos +: 8])) name_ok = 1'b0;
          end else begin
            name_ok = 1'b0;
          end
          if (name_pos <= KEY_MAX_LEN) name_pos++;
        end
      end
      PH_SKIP_START: begin
        if (c == CH_DQUOTE) parse_ph = PH_SKIP_QUOTED;
        else if (c == CH_SEMI) parse_ph = PH_SKIPWS;
        else parse_ph = PH_SKIP_PLAIN;
      end
      PH_SKIP_PLAIN: begin
        if (c == CH_SEMI) parse_ph = PH_SKIPWS;
      end
      PH_SKIP_QUOTED: begin
        if (c == CH_DQUOTE) parse_ph = PH_SKIP_PLAIN;
        else if (c == CH_BSLASH) parse_ph = PH_SKIP_ESC;
      end
      PH_SKIP_ESC: parse_ph = PH_SKIP_QUOTED;
      PH_GET_START: parse_ph = PH_GET_QUOTED;
      PH_GET_PLAIN: begin
        if (token_char(c)) begin
          v = c;
          return 1'b1;
        end
        parse_ph = PH_DONE_FOUND;
      end
      PH_GET_QUOTED: begin
        if (c == CH_DQUOTE) begin
          parse_ph = PH_DONE_FOUND;
        end else if (c == CH_BSLASH) begin
          parse_ph = PH_GET_ESC;
        end else begin
          v = c;
          return 1'b1;
        end
      end
      PH_GET_ESC: begin
        parse_ph = PH_GET_QUOTED;
        v = c;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Queue the results that one accepted item should produce.
  function automatic void predict_char(input logic [7:0] c, input logic fin);
    logic [7:0] v;
    bit         emit;
    res_t       r;
    emit = 1'b0;
    if (c != CH_NUL) emit = advance_parse(c, v);
    if (emit) begin
      r.data = v;
      r.kind = KIND_VALUE;
      r.last = 1'b0;
      predicted_results.push_back(r);
    end
    // a NUL or the last flag closes the string with its status
    if (c == CH_NUL || fin) begin
      r.data = '0;
      r.kind = (parse_ph >= PH_GET_START && parse_ph <= PH_DONE_FOUND) ?
               KIND_FOUND : KIND_MISSING;
      r.last = 1'b1;
      predicted_results.push_back(r);
      parse_ph = PH_SKIPWS;
      name_pos = 0;
      name_ok = 1'b1;
    end
  endfunction

  // Mostly no gap; of the gaps, most short and a few long.
  function automatic int pick_gap(input int pct);
    if (!idling || $urandom_range(1, 100) > pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] rand_token();
    return token_set[$urandom_range(0, token_set.len() - 1)];
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] kv;
    for (int i = 0; i < 8; i++) kv[8*i +: 8] = rand_token();
    return kv;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [7:0] ch, input logic fin);
    pending_chars.push_back('{ch, fin});
    phase_items++;
  endtask

  // Push a literal string; end it with the last flag on its final character,
  // or with a NUL terminator.
  task automatic push_text(input string txt, input bit with_last);
    for (int i = 0; i < txt.len(); i++)
      add_item(txt[i], with_last && (i == txt.len() - 1));
    if (!with_last || txt.len() == 0) add_item(CH_NUL, 1'b0);
  endtask

  // Write one register. The block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_KEY_CHARS) key_bytes = val;
    else key_len = val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item has gone in and every result has come out, then let
  // the pipe settle before the next register write.
  task automatic drain();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_tvalid || predicted_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One parameter string: mostly well-formed lists built around the key, with
  // random case, quoting, escapes and junk; a tenth are raw noise bytes.
  task automatic gen_string();
    logic [7:0] s[$];
    logic [7:0] b;
    int         k;
    int         r;
    int         n;
    int         nparam;
    k = (key_len > KEY_MAX_LEN) ? KEY_MAX_LEN : int'(key_len);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      nparam = $urandom_range(1, 3);
      for (int p = 0; p < nparam; p++) begin
        if (p > 0) s.push_back(CH_SEMI);
        repeat ($urandom_range(0, 2))
          s.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        // name: the key itself, the key plus one, one short of it, or random
        r = $urandom_range(0, 99);
        if (r < 65 && k > 0) begin
          n = (r < 50) ? k : (r < 58) ? k + 1 : k - 1;
          for (int i = 0; i < n; i++) begin
            b = (i < k) ? key_bytes[8*i +: 8] : rand_token();
            if (b == CH_NUL) b = rand_token();
            if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(0, 1)) b ^= 8'h20;
            s.push_back(b);
          end
        end else begin
          repeat ($urandom_range(1, 5))
            s.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : rand_token());
        end
        // value: none, plain token run, or quoted
        r = $urandom_range(0, 99);
        if (r >= 10) begin
          s.push_back(CH_EQUALS);
          if (r < 55) begin
            repeat ($urandom_range(0, 6)) s.push_back(rand_token());
            if ($urandom_range(0, 4) == 0) begin
              s.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(127, 255)) :
                          stop_set[$urandom_range(0, stop_set.len() - 1)]);
              s.push_back(rand_token());
            end
          end else begin
            s.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 6)) begin
              r = $urandom_range(0, 9);
              if (r == 0) begin
                s.push_back(CH_BSLASH);
                s.push_back(8'($urandom_range(1, 255)));
              end else if (r == 1) begin
                s.push_back(CH_SEMI);
              end else begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_DQUOTE || b == CH_BSLASH) b = rand_token();
                s.push_back(b);
              end
            end
            if ($urandom_range(0, 6) != 0) s.push_back(CH_DQUOTE);
            if ($urandom_range(0, 4) == 0) s.push_back(rand_token());
          end
        end
      end
    end
    // close with the last flag, a NUL, or a NUL that also carries the flag
    r = $urandom_range(0, 9);
    for (int i = 0; i < s.size(); i++) add_item(s[i], (r < 6) && (i == s.size() - 1));
    if (r >= 6 || s.size() == 0) add_item(CH_NUL, r == 9);
  endtask

  task automatic run_phase(input logic [63:0] kv, input logic [3:0] len, input bit idle_on,
                           input int count);
    idling = idle_on;
    write_reg(REG_KEY_CHARS, kv);
    write_reg(REG_KEY_LENGTH, {60'd0, len});
    phase_items = 0;
    while (phase_items < count) gen_string();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offer queued items, with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : char_driver
    char_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      // hold the current item until it is taken
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          nxt = pending_chars.pop_front();
          in_tdata <= nxt.ch;
          in_tlast <= nxt.fin;
          in_tvalid <= 1'b1;
          in_gap = pick_gap(35);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each item with the oldest prediction, and stall
  // the result channel at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data = out_tdata;
        got.kind = out_tuser;
        got.last = out_tlast;
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item: byte %02h kind %0d last %0d",
                   $time, got.data, got.kind, got.last);
        end else begin
          want = predicted_results.pop_front();
          if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last) begin
            mismatches++;
            $display({"%0t: mismatch: expected byte %02h kind %0d last %0d, ",
                      "got byte %02h kind %0d last %0d"},
                     $time, want.data, want.kind, want.last, got.data, got.kind, got.last);
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (random_part && long_holds < 2 && pending_chars.size() > 40) begin
        // hold off for a long stretch while the sender keeps offering, so the
        // result queue fills and the input side has to stall
        out_hold = 120;
        long_holds++;
        out_tready <= 1'b0;
      end else begin
        out_hold = pick_gap(15);
        out_tready <= (out_hold == 0);
        if (out_hold > 0) out_hold--;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck == STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings against the key "ab"
    idling = 1'b1;
    write_reg(REG_KEY_CHARS, 64'h6261);
    write_reg(REG_KEY_LENGTH, 64'd2);
    push_text("\tAb=x", 1'b1);          // skip whitespace, mixed case, value and status together
    push_text("a=\";\";ab", 1'b0);      // quoted ';' in another value; key with no value
    push_text("ab=", 1'b1);             // found with an empty value
    push_text("ab=\"\\", 1'b1);         // trailing backslash inside an open quote
    push_text("", 1'b0);                // lone NUL
    add_item(8'hFF, 1'b1);              // top byte value, ends the string by itself
    drain();

    // random part: walk the key settings, extremes included
    random_part = 1'b1;
    run_phase(rand_key(), 4'd2, 1'b1, 55);
    run_phase(rand_key(), 4'd0, 1'b1, 55);                    // key length zero
    run_phase(rand_key(), 4'd15, 1'b0, 55);                   // saturates to eight
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 55);
    run_phase(64'h0, 4'd1, 1'b1, 55);                         // a zero key byte never matches
    run_phase(rand_key() & ~64'hFF00, 4'd3, 1'b1, 55);
    run_phase(rand_key(), 4'd4, 1'b1, 55);

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
